// File: design/wmt_pkg.sv
// Package for the wildcard match table: sizes, function and config codes,
// row cell and result types, and the byte mask helper. No dependencies.
`timescale 1ns / 1ps
package wmt_pkg;

  localparam int ENTRIES      = 16;
  localparam int FIELDS       = 4;
  localparam int ACTION_WIDTH = 16;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  localparam int KEY_W     = 64;
  localparam int NUM_FB    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;

  localparam logic [1:0] FN_FIELD  = 2'd0;
  localparam logic [1:0] FN_ACTION = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BYTES_0 = 3'd1;

  typedef struct packed {
    logic             wild;
    logic [KEY_W-1:0] value;
  } field_cell_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  matched_index;
    logic [15:0] action_out;
  } result_t;

  function automatic logic [KEY_W-1:0] byte_mask(input logic [3:0] nbytes);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nbytes) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// File: design/wmt_in_if.sv
// Input channel of the wildcard match table: valid, ready and one item.
// Depends on wmt_pkg for the key width.
`timescale 1ns / 1ps
interface wmt_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [3:0]              entry_index;
  logic [1:0]              field_index;
  logic [wmt_pkg::KEY_W-1:0] entry_value;
  logic                    entry_dontcare;
  logic [15:0]             action_word;
  logic [wmt_pkg::KEY_W-1:0] key_value_0;
  logic [wmt_pkg::KEY_W-1:0] key_value_1;
  logic [wmt_pkg::KEY_W-1:0] key_value_2;
  logic [wmt_pkg::KEY_W-1:0] key_value_3;

  modport source (
    output valid, func, entry_index, field_index, entry_value, entry_dontcare,
           action_word, key_value_0, key_value_1, key_value_2, key_value_3,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, field_index, entry_value, entry_dontcare,
           action_word, key_value_0, key_value_1, key_value_2, key_value_3,
    output ready
  );
endinterface

// File: design/wmt_out_if.sv
// Result channel of the wildcard match table: valid, ready and one result.
// No dependencies.
`timescale 1ns / 1ps
interface wmt_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  matched_index;
  logic [15:0] action_out;

  modport source (output valid, hit, matched_index, action_out, input ready);
  modport sink   (input valid, hit, matched_index, action_out, output ready);
endinterface

// File: design/wmt_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module wmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/wmt_row_match.sv
// Compares one table row, as read from the field memories, against the key.
// Depends on wmt_pkg for the cell type and the byte mask.
`timescale 1ns / 1ps
module wmt_row_match (
  input  wmt_pkg::field_cell_t [wmt_pkg::FIELDS-1:0]            cells,
  input  logic [wmt_pkg::FIELDS-1:0][wmt_pkg::KEY_W-1:0]        keys,
  input  logic [wmt_pkg::NUM_FB-1:0][3:0]                       field_bytes,
  output logic                                                  match
);
  import wmt_pkg::*;

  logic [FIELDS-1:0] field_ok;

  always_comb begin
    for (int f = 0; f < FIELDS; f++) begin
      field_ok[f] = cells[f].wild ||
                    (((keys[f] ^ cells[f].value) & byte_mask(field_bytes[f])) == '0);
    end
  end

  assign match = &field_ok;
endmodule

// File: design/wildcard_match_table_lookup.sv
// Wildcard match table, top level: config registers, field and action
// memories, scan sequencer and result register. Uses wmt_pkg, wmt_in_if,
// wmt_out_if, wmt_ram and wmt_row_match.
// Write beats are taken while idle. A lookup scans one row per cycle from the
// memories, up to min(entry_count, 16) rows; on a hit or after the last row, or
// at once when that limit is 0, the result is loaded into the result register
// once that register is free, and the next beat is taken when back in idle.
// Synchronous reset clears the control state and the config registers
// (entry_count 0, byte counts 8); table contents are left as they are.
`timescale 1ns / 1ps
module wildcard_match_table_lookup (
  input  logic                              clk,
  input  logic                              rst_n,
  wmt_in_if.sink                            in_ch,
  wmt_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmt_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import wmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [4:0]                    entry_count_r;
  logic [NUM_FB-1:0][3:0]        field_bytes_r;
  logic [IDX_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic [FIELDS-1:0][KEY_W-1:0]  key_r;
  logic [NUM_FB-1:0][KEY_W-1:0]  key_all;
  result_t                       res_r, res_nxt;
  result_t                       out_res_r;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_acc;
  logic                          lookup_acc;
  logic [LIM_W-1:0]              limit;
  logic                          last_row;
  logic                          out_load;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  field_cell_t [FIELDS-1:0]      cells_rd;
  logic [ACTION_WIDTH-1:0]       action_rd;
  logic                          row_hit;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign lookup_acc = in_acc && (in_ch.func == FN_LOOKUP);
  assign in_ch.ready = (state_r == S_IDLE);

  assign limit = (LIM_W'(entry_count_r) < LIM_W'(ENTRIES)) ?
                 LIM_W'(entry_count_r) : LIM_W'(ENTRIES);
  assign last_row = (LIM_W'(cmp_idx_r) == (limit - LIM_W'(1)));

  assign key_all[0] = in_ch.key_value_0;
  assign key_all[1] = in_ch.key_value_1;
  assign key_all[2] = in_ch.key_value_2;
  assign key_all[3] = in_ch.key_value_3;

  assign rd_addr = (state_r == S_SCAN) ? (cmp_idx_r + IDX_W'(1)) : '0;
  assign wr_addr = IDX_W'(in_ch.entry_index);

  for (genvar f = 0; f < FIELDS; f++) begin : g_field
    logic        fwe;
    field_cell_t fwd;
    assign fwe = in_acc && (in_ch.func == FN_FIELD) &&
                 (32'(in_ch.entry_index) < ENTRIES) && (in_ch.field_index == 2'(f));
    assign fwd = '{wild: in_ch.entry_dontcare, value: in_ch.entry_value};
    wmt_ram #(.WIDTH($bits(field_cell_t)), .DEPTH(ENTRIES)) u_field_ram (
      .clk   (clk),
      .we    (fwe),
      .waddr (wr_addr),
      .wdata (fwd),
      .raddr (rd_addr),
      .rdata (cells_rd[f])
    );
  end

  wmt_ram #(.WIDTH(ACTION_WIDTH), .DEPTH(ENTRIES)) u_action_ram (
    .clk   (clk),
    .we    (in_acc && (in_ch.func == FN_ACTION) && (32'(in_ch.entry_index) < ENTRIES)),
    .waddr (wr_addr),
    .wdata (ACTION_WIDTH'(in_ch.action_word)),
    .raddr (rd_addr),
    .rdata (action_rd)
  );

  wmt_row_match u_row_match (
    .cells       (cells_rd),
    .keys        (key_r),
    .field_bytes (field_bytes_r),
    .match       (row_hit)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    cmp_idx_nxt = cmp_idx_r;
    res_nxt     = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (lookup_acc) begin
          cmp_idx_nxt = '0;
          res_nxt     = '0;
          state_nxt   = (limit == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (row_hit) begin
          res_nxt.hit           = 1'b1;
          res_nxt.matched_index = 4'(cmp_idx_r);
          res_nxt.action_out    = 16'(action_rd);
          state_nxt             = S_DONE;
        end else if (last_row) begin
          state_nxt = S_DONE;
        end else begin
          cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= 5'd0;
      for (int i = 0; i < NUM_FB; i++) begin
        field_bytes_r[i] <= 4'd8;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_ENTRY_COUNT) begin
          entry_count_r <= cfg_wdata[4:0];
        end
        for (int i = 0; i < NUM_FB; i++) begin
          if (cfg_index == CFG_IDX_W'(CFG_FIELD_BYTES_0 + i)) begin
            field_bytes_r[i] <= cfg_wdata[3:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
    if (lookup_acc) begin
      for (int f = 0; f < FIELDS; f++) begin
        key_r[f] <= key_all[f];
      end
    end
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_res_r.hit;
  assign out_ch.matched_index = out_res_r.matched_index;
  assign out_ch.action_out    = out_res_r.action_out;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (LIM_W'(cmp_idx_r) < limit))
    else $error("scan row beyond entry limit");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !res_r.hit) |->
      ((res_r.matched_index == 4'd0) && (res_r.action_out == 16'd0)))
    else $error("miss result carries non-zero fields");

  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_acc |=> !in_ch.ready)
    else $error("new beat taken while a lookup is pending");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished lookup not presented");
endmodule
